// ----- rtl/core/frnf_pkg.sv -----
`timescale 1ns / 1ps

package frnf_pkg;

   localparam int MAX_SENSORS  = 64;
   localparam int COORD_WIDTH  = 20;
   localparam int RADIUS_WIDTH = 19;
   localparam int OPCODE_WIDTH = 2;
   localparam int QIDX_WIDTH   = 6;
   localparam int STATUS_WIDTH = 3;
   localparam int NIDX_WIDTH   = 6;

   localparam int IDX_WIDTH   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
   localparam int CNT_WIDTH   = $clog2(MAX_SENSORS + 1);
   localparam int CMP_WIDTH   = QIDX_WIDTH + 1;
   localparam int ENTRY_WIDTH = 2 * COORD_WIDTH;
   localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
   localparam int DIST_WIDTH  = SQ_WIDTH + 1;
   localparam int R2_WIDTH    = 2 * RADIUS_WIDTH;
   localparam int CMPD_WIDTH  = (DIST_WIDTH > R2_WIDTH) ? DIST_WIDTH : R2_WIDTH;

   localparam int RSP_FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_WIDTH  = $clog2(RSP_FIFO_DEPTH);
   localparam int FIFO_CNT_WIDTH  = $clog2(RSP_FIFO_DEPTH + 1);
   localparam int INFLIGHT_WIDTH  = FIFO_CNT_WIDTH;
   localparam int CREDIT_WIDTH    = INFLIGHT_WIDTH + 1;

   localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = RADIUS_WIDTH'(2560);

   localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_LOAD   = 2'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_TARGET = 2'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_SENSOR = 2'd3;

   localparam logic [STATUS_WIDTH-1:0] ST_FOUND  = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_NONE   = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_OK     = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL   = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_BADIDX = 3'd4;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0]       opcode;
      logic signed [COORD_WIDTH-1:0] x_coord;
      logic signed [COORD_WIDTH-1:0] y_coord;
      logic [QIDX_WIDTH-1:0]         query_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [NIDX_WIDTH-1:0]   neighbor_index;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [IDX_WIDTH-1:0] idx;
   } scan_tag_type;

   typedef struct packed {
      logic                 valid;
      logic                 hit;
      logic [IDX_WIDTH-1:0] idx;
   } match_type;

endpackage

// ----- rtl/core/fixed_radius_neighbor_finder_unit.sv -----
`timescale 1ns / 1ps
// clear, load and rejected items: one result, valid the cycle after the item is taken,
// and a new item can be taken every cycle while the result queue is not full
// target query: scans the table with at most one table read a cycle; a sensor query first
// fetches its own entry from the table and skips that entry in the scan; table reads pause
// while the 8-entry result queue is short of room
// reset: sensor count zero, radius 10.0, result queue empty; table contents are kept

module fixed_radius_neighbor_finder_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  frnf_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output frnf_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [frnf_pkg::RADIUS_WIDTH-1:0] csr_data
);

   localparam int CW = frnf_pkg::COORD_WIDTH;
   localparam int IW = frnf_pkg::IDX_WIDTH;
   localparam int NW = frnf_pkg::CNT_WIDTH;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;

   logic [1:0]                            state_ff, state_in;
   logic [NW-1:0]                         count_ff, count_in;
   logic [frnf_pkg::RADIUS_WIDTH-1:0]     radius_ff, radius_in;
   logic [NW-1:0]                         scan_idx_ff, scan_idx_in;
   logic                                  skip_en_ff, skip_en_in;
   logic [IW-1:0]                         skip_idx_ff, skip_idx_in;
   logic signed [CW-1:0]                  qx_ff, qx_in;
   logic signed [CW-1:0]                  qy_ff, qy_in;
   logic                                  pend_valid_ff, pend_valid_in;
   logic [IW-1:0]                         pend_idx_ff, pend_idx_in;
   logic [frnf_pkg::INFLIGHT_WIDTH-1:0]   inflight_ff, inflight_in;
   frnf_pkg::scan_tag_type                rd_tag_ff, rd_tag_in;

   frnf_pkg::rsp_type                     fifo_mem_ff [frnf_pkg::RSP_FIFO_DEPTH];
   logic [frnf_pkg::FIFO_PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [frnf_pkg::FIFO_CNT_WIDTH-1:0]   fifo_cnt_ff;
   logic                                  fifo_full;
   logic                                  push;
   logic                                  pop;
   frnf_pkg::rsp_type                     push_data;

   logic                                  wr_en;
   logic [IW-1:0]                         wr_addr;
   logic [frnf_pkg::ENTRY_WIDTH-1:0]      wr_data;
   logic                                  rd_en;
   logic [IW-1:0]                         rd_addr;
   logic [frnf_pkg::ENTRY_WIDTH-1:0]      rd_data;
   logic signed [CW-1:0]                  entry_x;
   logic signed [CW-1:0]                  entry_y;

   logic                                  req_accept;
   logic                                  issue;
   logic                                  credit_ok;
   logic [frnf_pkg::CREDIT_WIDTH-1:0]     credit_sum;
   logic                                  bad_index;
   frnf_pkg::match_type                   match;

   frnf_ram #(
      .WIDTH (frnf_pkg::ENTRY_WIDTH),
      .DEPTH (frnf_pkg::MAX_SENSORS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign entry_x = rd_data[frnf_pkg::ENTRY_WIDTH-1 -: CW];
   assign entry_y = rd_data[CW-1:0];

   frnf_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .tag     (rd_tag_ff),
      .entry_x (entry_x),
      .entry_y (entry_y),
      .query_x (qx_ff),
      .query_y (qy_ff),
      .radius  (radius_ff),
      .match   (match)
   );

   assign csr_ready = 1'b1;
   assign radius_in = csr_valid ? csr_data : radius_ff;

   assign fifo_full  = fifo_cnt_ff == frnf_pkg::FIFO_CNT_WIDTH'(frnf_pkg::RSP_FIFO_DEPTH);
   assign rsp_valid  = fifo_cnt_ff != '0;
   assign rsp_data   = fifo_mem_ff[rd_ptr_ff];
   assign pop        = rsp_valid && rsp_ready;
   assign req_ready  = (state_ff == S_IDLE) && !fifo_full;
   assign req_accept = req_valid && req_ready;

   assign bad_index = frnf_pkg::CMP_WIDTH'(req_data.query_index)
                      >= frnf_pkg::CMP_WIDTH'(count_ff);

   // every issued read may push one item, so keep room for all of them
   assign credit_sum = frnf_pkg::CREDIT_WIDTH'(fifo_cnt_ff)
                     + frnf_pkg::CREDIT_WIDTH'(inflight_ff)
                     + frnf_pkg::CREDIT_WIDTH'(1);
   assign credit_ok  = credit_sum <= frnf_pkg::CREDIT_WIDTH'(frnf_pkg::RSP_FIFO_DEPTH);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      skip_en_in    = skip_en_ff;
      skip_idx_in   = skip_idx_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      rd_tag_in     = '0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IW-1:0];
      wr_data       = {req_data.x_coord, req_data.y_coord};
      rd_en         = 1'b0;
      rd_addr       = scan_idx_ff[IW-1:0];
      issue         = 1'b0;
      push          = 1'b0;
      push_data     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_data.opcode)
                  frnf_pkg::OP_CLEAR: begin
                     count_in  = '0;
                     push      = 1'b1;
                     push_data = '{frnf_pkg::ST_OK, '0, 1'b1};
                  end
                  frnf_pkg::OP_LOAD: begin
                     push = 1'b1;
                     if (count_ff == NW'(frnf_pkg::MAX_SENSORS)) begin
                        push_data = '{frnf_pkg::ST_FULL, '0, 1'b1};
                     end else begin
                        wr_en     = 1'b1;
                        count_in  = count_ff + NW'(1);
                        push_data = '{frnf_pkg::ST_OK, '0, 1'b1};
                     end
                  end
                  frnf_pkg::OP_TARGET: begin
                     qx_in       = req_data.x_coord;
                     qy_in       = req_data.y_coord;
                     skip_en_in  = 1'b0;
                     scan_idx_in = '0;
                     state_in    = S_SCAN;
                  end
                  frnf_pkg::OP_SENSOR: begin
                     if (bad_index) begin
                        push      = 1'b1;
                        push_data = '{frnf_pkg::ST_BADIDX, '0, 1'b1};
                     end else begin
                        rd_en       = 1'b1;
                        rd_addr     = req_data.query_index[IW-1:0];
                        skip_en_in  = 1'b1;
                        skip_idx_in = req_data.query_index[IW-1:0];
                        scan_idx_in = '0;
                        state_in    = S_FETCH;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FETCH: begin
            qx_in    = entry_x;
            qy_in    = entry_y;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_idx_ff < count_ff) begin
               if (skip_en_ff && (scan_idx_ff[IW-1:0] == skip_idx_ff)) begin
                  scan_idx_in = scan_idx_ff + NW'(1);
               end else if (credit_ok) begin
                  rd_en           = 1'b1;
                  issue           = 1'b1;
                  rd_tag_in.valid = 1'b1;
                  rd_tag_in.idx   = scan_idx_ff[IW-1:0];
                  scan_idx_in     = scan_idx_ff + NW'(1);
               end
            end else if ((inflight_ff == '0) && !fifo_full) begin
               push          = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
               if (pend_valid_ff) begin
                  push_data = '{frnf_pkg::ST_FOUND,
                                frnf_pkg::NIDX_WIDTH'(pend_idx_ff), 1'b1};
               end else begin
                  push_data = '{frnf_pkg::ST_NONE, '0, 1'b1};
               end
            end
            // hold back the newest match until the next one shows whether it is the last
            if (match.valid && match.hit) begin
               if (pend_valid_ff) begin
                  push      = 1'b1;
                  push_data = '{frnf_pkg::ST_FOUND,
                                frnf_pkg::NIDX_WIDTH'(pend_idx_ff), 1'b0};
               end
               pend_valid_in = 1'b1;
               pend_idx_in   = match.idx;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      inflight_in = inflight_ff + frnf_pkg::INFLIGHT_WIDTH'(issue)
                  - frnf_pkg::INFLIGHT_WIDTH'(match.valid);
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      skip_en_ff    <= skip_en_in;
      skip_idx_ff   <= skip_idx_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      pend_idx_ff   <= pend_idx_in;
      rd_tag_ff.idx <= rd_tag_in.idx;
      if (push) begin
         fifo_mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         radius_ff       <= frnf_pkg::RADIUS_RESET;
         pend_valid_ff   <= 1'b0;
         inflight_ff     <= '0;
         rd_tag_ff.valid <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         fifo_cnt_ff     <= '0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         radius_ff       <= radius_in;
         pend_valid_ff   <= pend_valid_in;
         inflight_ff     <= inflight_in;
         rd_tag_ff.valid <= rd_tag_in.valid;
         wr_ptr_ff       <= wr_ptr_ff + frnf_pkg::FIFO_PTR_WIDTH'(push);
         rd_ptr_ff       <= rd_ptr_ff + frnf_pkg::FIFO_PTR_WIDTH'(pop);
         fifo_cnt_ff     <= fifo_cnt_ff + frnf_pkg::FIFO_CNT_WIDTH'(push)
                          - frnf_pkg::FIFO_CNT_WIDTH'(pop);
      end
   end

endmodule

// ----- rtl/core/frnf_ram.sv -----
`timescale 1ns / 1ps

module frnf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/frnf_dist.sv -----
`timescale 1ns / 1ps

module frnf_dist (
   input  logic                                  clock,
   input  logic                                  reset,
   input  frnf_pkg::scan_tag_type                tag,
   input  logic signed [frnf_pkg::COORD_WIDTH-1:0] entry_x,
   input  logic signed [frnf_pkg::COORD_WIDTH-1:0] entry_y,
   input  logic signed [frnf_pkg::COORD_WIDTH-1:0] query_x,
   input  logic signed [frnf_pkg::COORD_WIDTH-1:0] query_y,
   input  logic [frnf_pkg::RADIUS_WIDTH-1:0]       radius,
   output frnf_pkg::match_type                   match
);

   localparam int CW = frnf_pkg::COORD_WIDTH;

   logic signed [CW:0]                dx_full;
   logic signed [CW:0]                dy_full;
   logic signed [CW:0]                dx_abs;
   logic signed [CW:0]                dy_abs;
   logic [frnf_pkg::CMPD_WIDTH-1:0]   dist_sum;
   logic                              hit_in;

   logic [frnf_pkg::R2_WIDTH-1:0]     r2_ff;
   logic [CW-1:0]                     ax_ff;
   logic [CW-1:0]                     ay_ff;
   logic [frnf_pkg::SQ_WIDTH-1:0]     sqx_ff;
   logic [frnf_pkg::SQ_WIDTH-1:0]     sqy_ff;
   frnf_pkg::scan_tag_type            tag_s1_ff;
   frnf_pkg::scan_tag_type            tag_s2_ff;
   frnf_pkg::match_type               match_ff;

   // absolute coordinate differences
   assign dx_full = {entry_x[CW-1], entry_x} - {query_x[CW-1], query_x};
   assign dy_full = {entry_y[CW-1], entry_y} - {query_y[CW-1], query_y};
   assign dx_abs  = dx_full[CW] ? -dx_full : dx_full;
   assign dy_abs  = dy_full[CW] ? -dy_full : dy_full;

   assign dist_sum = frnf_pkg::CMPD_WIDTH'(sqx_ff) + frnf_pkg::CMPD_WIDTH'(sqy_ff);
   assign hit_in   = dist_sum < frnf_pkg::CMPD_WIDTH'(r2_ff);

   always_ff @(posedge clock) begin
      r2_ff  <= frnf_pkg::R2_WIDTH'(radius) * frnf_pkg::R2_WIDTH'(radius);
      ax_ff  <= dx_abs[CW-1:0];
      ay_ff  <= dy_abs[CW-1:0];
      sqx_ff <= frnf_pkg::SQ_WIDTH'(ax_ff) * frnf_pkg::SQ_WIDTH'(ax_ff);
      sqy_ff <= frnf_pkg::SQ_WIDTH'(ay_ff) * frnf_pkg::SQ_WIDTH'(ay_ff);
      tag_s1_ff.idx <= tag.idx;
      tag_s2_ff.idx <= tag_s1_ff.idx;
      match_ff.idx  <= tag_s2_ff.idx;
      match_ff.hit  <= hit_in;
      if (reset) begin
         tag_s1_ff.valid <= 1'b0;
         tag_s2_ff.valid <= 1'b0;
         match_ff.valid  <= 1'b0;
      end else begin
         tag_s1_ff.valid <= tag.valid;
         tag_s2_ff.valid <= tag_s1_ff.valid;
         match_ff.valid  <= tag_s2_ff.valid;
      end
   end

   assign match = match_ff;

endmodule

// ----- rtl/core/frnf_checker.sv -----
`timescale 1ns / 1ps

module frnf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input frnf_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input frnf_pkg::rsp_type rsp_data
);

   // results never appear straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item shown right after reset");

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // anything other than a neighbor is a lone closing item with a zero index
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != frnf_pkg::ST_FOUND)
      |-> rsp_data.last && (rsp_data.neighbor_index == '0))
      else $error("non-neighbor result not closing or with index");

   // a target query holds off the next item while it scans
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.opcode == frnf_pkg::OP_TARGET)
      |=> !req_ready)
      else $error("item taken while a query scans");

endmodule

bind fixed_radius_neighbor_finder_unit frnf_checker u_frnf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int STALL_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 126;
   localparam int DRAIN_CYCLES = 100;
   localparam int REQ_BITS     = $bits(frnf_pkg::req_type);
   localparam int RADIUS_MAX   = (1 << frnf_pkg::RADIUS_WIDTH) - 1;

   typedef enum {ROW_ITEM, ROW_RADIUS} row_kind_type;

   typedef struct {
      row_kind_type                      kind;
      logic [frnf_pkg::OPCODE_WIDTH-1:0] opcode;
      int                                x;
      int                                y;
      int                                qidx;
      int                                radius_value;
      bit                                typed;
      logic [frnf_pkg::STATUS_WIDTH-1:0] want_status;
   } stim_row_type;

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   frnf_pkg::req_type                 req_data = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   frnf_pkg::rsp_type                 rsp_data;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [frnf_pkg::RADIUS_WIDTH-1:0] csr_data = frnf_pkg::RADIUS_RESET;

   // local copy of the sensor table and radius
   logic signed [frnf_pkg::COORD_WIDTH-1:0] point_x [frnf_pkg::MAX_SENSORS];
   logic signed [frnf_pkg::COORD_WIDTH-1:0] point_y [frnf_pkg::MAX_SENSORS];
   int                                      point_count = 0;
   logic [frnf_pkg::RADIUS_WIDTH-1:0]       radius_q = frnf_pkg::RADIUS_RESET;

   frnf_pkg::rsp_type pending_answers [$];
   frnf_pkg::rsp_type fresh_answers [$];
   stim_row_type      stim_table [$];
   int                error_count = 0;
   int                snd_idle_pct = 0;
   int                rcv_idle_pct = 0;
   int                stall_cycles = 0;
   int                center_x = 0;
   int                center_y = 0;

   fixed_radius_neighbor_finder_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void answer_once(input logic [frnf_pkg::STATUS_WIDTH-1:0] status);
      fresh_answers.push_back(frnf_pkg::rsp_type'{status: status, neighbor_index: '0,
                                                  last: 1'b1});
   endfunction

   function automatic void scan_neighbors(
      input logic signed [frnf_pkg::COORD_WIDTH-1:0] qx,
      input logic signed [frnf_pkg::COORD_WIDTH-1:0] qy,
      input int skip);
      longint r2;
      longint dx;
      longint dy;
      int     hits [$];
      r2 = longint'(radius_q) * longint'(radius_q);
      for (int i = 0; i < point_count; i++) begin
         if (i != skip) begin
            dx = longint'(point_x[i]) - longint'(qx);
            dy = longint'(point_y[i]) - longint'(qy);
            if (dx * dx + dy * dy < r2) hits.push_back(i);
         end
      end
      if (hits.size() == 0) begin
         answer_once(frnf_pkg::ST_NONE);
      end else begin
         foreach (hits[k]) begin
            fresh_answers.push_back(frnf_pkg::rsp_type'{
               status: frnf_pkg::ST_FOUND,
               neighbor_index: frnf_pkg::NIDX_WIDTH'(hits[k]),
               last: (k == hits.size() - 1)});
         end
      end
   endfunction

   function automatic void answer_item(input frnf_pkg::req_type it);
      int qi;
      qi = int'(it.query_index);
      case (it.opcode)
         frnf_pkg::OP_CLEAR: begin
            point_count = 0;
            answer_once(frnf_pkg::ST_OK);
         end
         frnf_pkg::OP_LOAD: begin
            if (point_count >= frnf_pkg::MAX_SENSORS) begin
               answer_once(frnf_pkg::ST_FULL);
            end else begin
               point_x[point_count] = it.x_coord;
               point_y[point_count] = it.y_coord;
               point_count++;
               answer_once(frnf_pkg::ST_OK);
            end
         end
         frnf_pkg::OP_TARGET: scan_neighbors(it.x_coord, it.y_coord, -1);
         default: begin
            if (qi >= point_count) answer_once(frnf_pkg::ST_BADIDX);
            else scan_neighbors(point_x[qi], point_y[qi], qi);
         end
      endcase
   endfunction

   task automatic send_item(input frnf_pkg::req_type it, input bit typed,
                            input logic [frnf_pkg::STATUS_WIDTH-1:0] want);
      fresh_answers.delete();
      answer_item(it);
      if (typed) begin
         pending_answers.push_back(frnf_pkg::rsp_type'{status: want, neighbor_index: '0,
                                                       last: 1'b1});
      end else begin
         foreach (fresh_answers[k]) pending_answers.push_back(fresh_answers[k]);
      end
      if ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < snd_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_radius(input int value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= frnf_pkg::RADIUS_WIDTH'(value);
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      radius_q = frnf_pkg::RADIUS_WIDTH'(value);
   endtask

   function automatic int pick_radius();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return RADIUS_MAX;
         2: return int'(frnf_pkg::RADIUS_RESET);
         3: return $urandom_range(1, 4096);
         4: return $urandom_range(0, RADIUS_MAX);
         default: return $urandom_range(256, 65535);
      endcase
   endfunction

   function automatic logic signed [frnf_pkg::COORD_WIDTH-1:0] near_center(input int c);
      int spread;
      if ($urandom_range(0, 7) == 0) return frnf_pkg::COORD_WIDTH'($urandom());
      spread = 2 * int'(radius_q) + 8;
      return frnf_pkg::COORD_WIDTH'(c + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   function automatic frnf_pkg::req_type random_item();
      return frnf_pkg::req_type'(REQ_BITS'({$urandom(), $urandom()}));
   endfunction

   function automatic void add_item(input logic [frnf_pkg::OPCODE_WIDTH-1:0] op,
                                    input int x, input int y, input int qi,
                                    input bit typed,
                                    input logic [frnf_pkg::STATUS_WIDTH-1:0] want);
      stim_table.push_back('{ROW_ITEM, op, x, y, qi, 0, typed, want});
   endfunction

   function automatic void add_radius(input int value);
      stim_table.push_back('{ROW_RADIUS, frnf_pkg::OP_CLEAR, 0, 0, 0, value, 1'b0,
                             frnf_pkg::ST_OK});
   endfunction

   task automatic run_random(input int quota);
      int                sent;
      int                n_load;
      int                n_query;
      frnf_pkg::req_type it;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(0, 9) == 0) drain_results();
         if ($urandom_range(0, 11) == 0) begin
            send_item(random_item(), 1'b0, frnf_pkg::ST_OK);
            sent++;
         end else begin
            center_x = int'($urandom_range(0, 1048575)) - 524288;
            center_y = int'($urandom_range(0, 1048575)) - 524288;
            if ($urandom_range(0, 3) != 0) begin
               it = random_item();
               it.opcode = frnf_pkg::OP_CLEAR;
               send_item(it, 1'b0, frnf_pkg::ST_OK);
               sent++;
            end
            if ($urandom_range(0, 24) == 0)
               n_load = frnf_pkg::MAX_SENSORS - point_count + $urandom_range(1, 3);
            else
               n_load = $urandom_range(1, 10);
            repeat (n_load) begin
               it = random_item();
               it.opcode  = frnf_pkg::OP_LOAD;
               it.x_coord = near_center(center_x);
               it.y_coord = near_center(center_y);
               send_item(it, 1'b0, frnf_pkg::ST_OK);
               sent++;
            end
            n_query = $urandom_range(1, 8);
            repeat (n_query) begin
               it = random_item();
               if ($urandom_range(0, 1) == 0) begin
                  it.opcode  = frnf_pkg::OP_TARGET;
                  it.x_coord = near_center(center_x);
                  it.y_coord = near_center(center_y);
               end else begin
                  it.opcode = frnf_pkg::OP_SENSOR;
                  if ($urandom_range(0, 7) != 0 && point_count > 0)
                     it.query_index =
                        frnf_pkg::QIDX_WIDTH'($urandom_range(0, point_count - 1));
               end
               send_item(it, 1'b0, frnf_pkg::ST_OK);
               sent++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin
      frnf_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_answers.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item, got status %0d index %0d last %0b",
                     $time, rsp_data.status, rsp_data.neighbor_index, rsp_data.last);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data !== want) begin
               error_count++;
               $display("%0t: expected status %0d index %0d last %0b, got %0d %0d %0b",
                        $time, want.status, want.neighbor_index, want.last,
                        rsp_data.status, rsp_data.neighbor_index, rsp_data.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)
          || (csr_valid && csr_ready === 1'b1))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      frnf_pkg::req_type it;
      // empty table after reset
      add_item(frnf_pkg::OP_TARGET, 0, 0, 0, 1'b1, frnf_pkg::ST_NONE);
      add_item(frnf_pkg::OP_SENSOR, 0, 0, 0, 1'b1, frnf_pkg::ST_BADIDX);
      add_item(frnf_pkg::OP_CLEAR, 0, 0, 0, 1'b1, frnf_pkg::ST_OK);
      add_item(frnf_pkg::OP_LOAD, 0, 0, 0, 1'b1, frnf_pkg::ST_OK);
      add_item(frnf_pkg::OP_LOAD, 256, 0, 0, 1'b1, frnf_pkg::ST_OK);
      // exactly on the radius
      add_item(frnf_pkg::OP_LOAD, 2560, 0, 0, 1'b1, frnf_pkg::ST_OK);
      add_item(frnf_pkg::OP_LOAD, 0, -2559, 0, 1'b1, frnf_pkg::ST_OK);
      add_item(frnf_pkg::OP_LOAD, 524287, 524287, 0, 1'b1, frnf_pkg::ST_OK);
      add_item(frnf_pkg::OP_LOAD, -524288, -524288, 0, 1'b1, frnf_pkg::ST_OK);
      add_item(frnf_pkg::OP_TARGET, 0, 0, 0, 1'b0, frnf_pkg::ST_OK);
      add_item(frnf_pkg::OP_TARGET, 2560, 0, 0, 1'b0, frnf_pkg::ST_OK);
      add_item(frnf_pkg::OP_SENSOR, 0, 0, 0, 1'b0, frnf_pkg::ST_OK);
      add_item(frnf_pkg::OP_SENSOR, 0, 0, 4, 1'b0, frnf_pkg::ST_OK);
      add_item(frnf_pkg::OP_SENSOR, 0, 0, 6, 1'b1, frnf_pkg::ST_BADIDX);
      add_item(frnf_pkg::OP_SENSOR, 0, 0, 63, 1'b1, frnf_pkg::ST_BADIDX);
      add_radius(0);
      add_item(frnf_pkg::OP_TARGET, 0, 0, 0, 1'b1, frnf_pkg::ST_NONE);
      add_item(frnf_pkg::OP_SENSOR, 0, 0, 1, 1'b1, frnf_pkg::ST_NONE);
      add_radius(RADIUS_MAX);
      add_item(frnf_pkg::OP_TARGET, -524288, 524287, 0, 1'b0, frnf_pkg::ST_OK);
      add_item(frnf_pkg::OP_SENSOR, 0, 0, 5, 1'b0, frnf_pkg::ST_OK);
      add_item(frnf_pkg::OP_CLEAR, 0, 0, 0, 1'b1, frnf_pkg::ST_OK);
      add_item(frnf_pkg::OP_TARGET, 0, 0, 0, 1'b1, frnf_pkg::ST_NONE);
      add_item(frnf_pkg::OP_SENSOR, 0, 0, 0, 1'b1, frnf_pkg::ST_BADIDX);
      add_radius(int'(frnf_pkg::RADIUS_RESET));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      snd_idle_pct = 19;
      rcv_idle_pct = 62;

      foreach (stim_table[k]) begin
         if (stim_table[k].kind == ROW_RADIUS) begin
            write_radius(stim_table[k].radius_value);
         end else begin
            it = '0;
            it.opcode      = stim_table[k].opcode;
            it.x_coord     = frnf_pkg::COORD_WIDTH'(stim_table[k].x);
            it.y_coord     = frnf_pkg::COORD_WIDTH'(stim_table[k].y);
            it.query_index = frnf_pkg::QIDX_WIDTH'(stim_table[k].qidx);
            send_item(it, stim_table[k].typed, stim_table[k].want_status);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         snd_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 62 : 0;
         rcv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 19 : 0;
         repeat (3) begin
            write_radius(pick_radius());
            run_random(PHASE_ITEMS / 3);
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
